// ===== design/cosine_similarity_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef COSINE_SIMILARITY_UNIT_DEFINES_SVH
`define COSINE_SIMILARITY_UNIT_DEFINES_SVH

// same-cycle implication
`define COSU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define COSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cosu_pkg.sv =====
// ---------------------------------------------------------------------------
// cosu_pkg
// Shared constants, controller states and command/status types of the
// cosine similarity unit.
// ---------------------------------------------------------------------------
package cosu_pkg;

    localparam int MAX_LEN_DEF    = 4096;
    localparam int ELEM_WIDTH_DEF = 16;

    // result is signed Q1.15
    localparam int SIM_W     = 16;
    localparam int ROOT_BITS = 16;
    localparam int IDX_W     = 4;

    typedef enum logic [2:0] {
        S_ACC,
        S_PREP,
        S_MUL,
        S_CAND,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             acc_en;
        logic             clear;
        logic             prep;
        logic             mul_step;
        logic             root_cand;
        logic             root_cmp;
        logic             load_out;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic out_full;
    } t_sts;

endpackage

// ===== design/cosu_in_if.sv =====
// ---------------------------------------------------------------------------
// cosu_in_if
// Element pair channel: valid/ready handshake with one pair per beat.
// ---------------------------------------------------------------------------
interface cosu_in_if #(
    parameter int ELEM_WIDTH = cosu_pkg::ELEM_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] a_elem;
    logic signed [ELEM_WIDTH-1:0] b_elem;
    logic                         has_pair;
    logic                         last;

    modport source (output valid, a_elem, b_elem, has_pair, last, input ready);
    modport sink   (input valid, a_elem, b_elem, has_pair, last, output ready);
endinterface

// ===== design/cosu_out_if.sv =====
// ---------------------------------------------------------------------------
// cosu_out_if
// Result channel: valid/ready handshake with one similarity per beat.
// ---------------------------------------------------------------------------
interface cosu_out_if #(
    parameter int CNT_W = 13
);
    logic                              valid;
    logic                              ready;
    logic signed [cosu_pkg::SIM_W-1:0] similarity;
    logic                              zero_norm;
    logic                              overflow;
    logic [CNT_W-1:0]                  element_count;

    modport source (output valid, similarity, zero_norm, overflow, element_count,
                    input ready);
    modport sink   (input valid, similarity, zero_norm, overflow, element_count,
                    output ready);
endinterface

// ===== design/cosu_datapath.sv =====
// ---------------------------------------------------------------------------
// cosu_datapath
// Accumulators, serial multipliers for the final products, bitwise root
// search for the Q1.15 ratio, and the output register.
// ---------------------------------------------------------------------------
module cosu_datapath #(
    parameter int MAX_LEN    = cosu_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = cosu_pkg::ELEM_WIDTH_DEF,
    parameter int CNT_W      = $clog2(MAX_LEN + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [ELEM_WIDTH-1:0]      i_a_elem,
    input  logic signed [ELEM_WIDTH-1:0]      i_b_elem,
    input  logic                              i_has_pair,
    input  cosu_pkg::t_cmd                    i_cmd,
    output cosu_pkg::t_sts                    o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [cosu_pkg::SIM_W-1:0] o_similarity,
    output logic                              o_zero_norm,
    output logic                              o_overflow,
    output logic [CNT_W-1:0]                  o_element_count
);
    import cosu_pkg::*;

    localparam int DOT_W = 2 * ELEM_WIDTH + $clog2(MAX_LEN);
    localparam int NRM_W = DOT_W - 1;
    localparam int PRD_W = 2 * DOT_W;
    localparam int CMP_W = 2 * DOT_W + 36;
    localparam int SH_W  = 6;

    // accumulators
    logic signed [DOT_W-1:0] r_dot;
    logic [NRM_W-1:0]        r_na;
    logic [NRM_W-1:0]        r_nb;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_ovf;

    logic signed [2*ELEM_WIDTH-1:0] prod_ab;
    logic signed [2*ELEM_WIDTH-1:0] prod_aa;
    logic signed [2*ELEM_WIDTH-1:0] prod_bb;

    assign prod_ab = i_a_elem * i_b_elem;
    assign prod_aa = i_a_elem * i_a_elem;
    assign prod_bb = i_b_elem * i_b_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.acc_en && i_has_pair) begin
            if (r_cnt == CNT_W'(MAX_LEN)) begin
                r_ovf <= 1'b1;
            end else begin
                r_dot <= r_dot + DOT_W'(prod_ab);
                r_na  <= r_na + NRM_W'(unsigned'(prod_aa));
                r_nb  <= r_nb + NRM_W'(unsigned'(prod_bb));
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // magnitude of the dot product
    logic [DOT_W-1:0] mag;
    assign mag = r_dot[DOT_W-1] ? DOT_W'(-r_dot) : DOT_W'(r_dot);

    // shift-add multipliers: m2 = mag*mag, p = na*nb
    logic             r_neg;
    logic [PRD_W-1:0] r_mc_a, r_mc_b, r_m2, r_p;
    logic [DOT_W-1:0] r_mr_a, r_mr_b;

    // root search state: largest q with (2q-1)^2 * p <= m2 * 2^32
    // ra = (2q)^2 * p, rb = 2q * p, candidates in ac/bc
    logic [CMP_W-1:0]     r_ra, r_rb, r_ac, r_bc;
    logic [ROOT_BITS-1:0] r_q;

    logic [SH_W-1:0]  sh_b, sh_p, sh_pb;
    logic [CMP_W-1:0] p_ext, cmp_lhs, cmp_rhs;

    assign p_ext   = CMP_W'(r_p);
    assign sh_b    = SH_W'(i_cmd.idx) + SH_W'(2);
    assign sh_p    = SH_W'({i_cmd.idx, 1'b0}) + SH_W'(2);
    assign sh_pb   = SH_W'(i_cmd.idx) + SH_W'(1);
    assign cmp_lhs = r_ac + p_ext;
    assign cmp_rhs = (CMP_W'(r_m2) << 32) + (r_bc << 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_neg  <= r_dot[DOT_W-1];
            r_mc_a <= PRD_W'(mag);
            r_mr_a <= mag;
            r_mc_b <= PRD_W'(r_na);
            r_mr_b <= DOT_W'(r_nb);
            r_m2   <= '0;
            r_p    <= '0;
            r_ra   <= '0;
            r_rb   <= '0;
            r_q    <= '0;
        end
        if (i_cmd.mul_step) begin
            if (r_mr_a[0]) begin
                r_m2 <= r_m2 + r_mc_a;
            end
            if (r_mr_b[0]) begin
                r_p <= r_p + r_mc_b;
            end
            r_mc_a <= r_mc_a << 1;
            r_mc_b <= r_mc_b << 1;
            r_mr_a <= r_mr_a >> 1;
            r_mr_b <= r_mr_b >> 1;
        end
        if (i_cmd.root_cand) begin
            r_ac <= r_ra + (r_rb << sh_b) + (p_ext << sh_p);
            r_bc <= r_rb + (p_ext << sh_pb);
        end
        if (i_cmd.root_cmp && (cmp_lhs <= cmp_rhs)) begin
            r_ra          <= r_ac;
            r_rb          <= r_bc;
            r_q[i_cmd.idx] <= 1'b1;
        end
    end

    // output register
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic signed [SIM_W-1:0] r_sim;
    logic                    r_zero;
    logic                    r_ovf_o;
    logic [CNT_W-1:0]        r_cnt_o;
    logic signed [SIM_W-1:0] sim_val;
    logic                    zero;

    assign zero = (r_cnt == '0) || (r_na == '0) || (r_nb == '0);

    always_comb begin
        if (zero) begin
            sim_val = '0;
        end else if (r_neg) begin
            sim_val = SIM_W'(-r_q);
        end else if (r_q[ROOT_BITS-1]) begin
            sim_val = {1'b0, {(SIM_W-1){1'b1}}};
        end else begin
            sim_val = SIM_W'(r_q);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_sim   <= sim_val;
            r_zero  <= zero;
            r_ovf_o <= r_ovf;
            r_cnt_o <= r_cnt;
        end
    end

    assign o_sts.zero      = zero;
    assign o_sts.out_full  = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_similarity    = r_sim;
    assign o_zero_norm     = r_zero;
    assign o_overflow      = r_ovf_o;
    assign o_element_count = r_cnt_o;

endmodule

// ===== design/cosu_ctrl.sv =====
// ---------------------------------------------------------------------------
// cosu_ctrl
// Sequencer: accumulate beats, then, unless a norm is zero, run the
// multiply and root search steps and hand the result to the output register.
// ---------------------------------------------------------------------------
module cosu_ctrl #(
    parameter int MAX_LEN    = cosu_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = cosu_pkg::ELEM_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    input  cosu_pkg::t_sts i_sts,
    output cosu_pkg::t_cmd o_cmd
);
    import cosu_pkg::*;

    localparam int DOT_W  = 2 * ELEM_WIDTH + $clog2(MAX_LEN);
    localparam int MCNT_W = $clog2(DOT_W);

    t_state r_state, n_state;
    logic [MCNT_W-1:0] r_mcnt, n_mcnt;
    logic [IDX_W-1:0]  r_bit, n_bit;
    logic              accept;
    logic              out_free;

    assign accept   = i_in_valid && (r_state == S_ACC);
    assign out_free = !i_sts.out_full || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACC: begin
                if (accept && i_in_last) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = i_sts.zero ? S_DONE : S_MUL;
            end
            S_MUL: begin
                if (r_mcnt == MCNT_W'(DOT_W - 1)) n_state = S_CAND;
            end
            S_CAND: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = (r_bit == '0) ? S_DONE : S_CAND;
            end
            S_DONE: begin
                if (out_free) n_state = S_ACC;
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_comb begin
        n_mcnt = (r_state == S_MUL) ? r_mcnt + 1'b1 : '0;
        n_bit  = r_bit;
        if (r_state == S_PREP) begin
            n_bit = IDX_W'(ROOT_BITS - 1);
        end else if (r_state == S_CMP) begin
            n_bit = r_bit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_mcnt  <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_mcnt  <= n_mcnt;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        o_in_ready         = (r_state == S_ACC);
        o_cmd.acc_en       = accept;
        o_cmd.prep         = (r_state == S_PREP);
        o_cmd.mul_step     = (r_state == S_MUL);
        o_cmd.root_cand    = (r_state == S_CAND);
        o_cmd.root_cmp     = (r_state == S_CMP);
        o_cmd.load_out     = (r_state == S_DONE) && out_free;
        o_cmd.clear        = (r_state == S_DONE) && out_free;
        o_cmd.idx          = r_bit;
    end

endmodule

// ===== design/cosine_similarity_unit.sv =====
// ---------------------------------------------------------------------------
// cosine_similarity_unit
// Accumulates dot product and squared norms of two vectors, one element
// pair per beat, and returns their cosine similarity as signed Q1.15.
// ---------------------------------------------------------------------------
//  channel   dir  payload                                          beat
//  i_in      in   a_elem, b_elem, has_pair, last                   one pair
//  o_out     out  similarity, zero_norm, overflow, element_count   one result
//
//  one beat per cycle while a vector pair streams in
//  after the last beat: a prepare step, a shift-add multiply, a root search
//  with a candidate and a compare step per result bit, and an output load;
//  a zero norm skips from the prepare step straight to the output load
//  input stays stalled during that sequence and while a finished result
//  cannot be loaded; reset clears all accumulators and the output valid
// ---------------------------------------------------------------------------
module cosine_similarity_unit #(
    parameter int MAX_LEN    = cosu_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = cosu_pkg::ELEM_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cosu_in_if.sink    i_in,
    cosu_out_if.source o_out
);
    import cosu_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    t_cmd cmd;
    t_sts sts;

    cosu_ctrl #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cosu_datapath #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_WIDTH),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_a_elem        (i_in.a_elem),
        .i_b_elem        (i_in.b_elem),
        .i_has_pair      (i_in.has_pair),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_similarity    (o_out.similarity),
        .o_zero_norm     (o_out.zero_norm),
        .o_overflow      (o_out.overflow),
        .o_element_count (o_out.element_count)
    );

endmodule

// ===== design/cosu_checker.sv =====
// ---------------------------------------------------------------------------
// cosu_checker
// Port-level checks of the cosine similarity unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "cosine_similarity_unit_defines.svh"

module cosu_checker #(
    parameter int MAX_LEN = cosu_pkg::MAX_LEN_DEF,
    parameter int CNT_W   = $clog2(MAX_LEN + 1)
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_in_last,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [cosu_pkg::SIM_W-1:0] i_out_sim,
    input logic                       i_out_zero,
    input logic [CNT_W-1:0]           i_out_cnt
);
    import cosu_pkg::*;

    `COSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_sim) && $stable(i_out_cnt), "stalled result changed")

    `COSU_ASSERT_IMP(a_zero_sim, i_clk, i_rst_n, i_out_valid && i_out_zero, i_out_sim == '0, "zero norm with nonzero similarity")

    `COSU_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, i_out_valid, i_out_cnt <= CNT_W'(MAX_LEN), "element count above maximum")

    `COSU_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last, !i_in_ready, "input taken right after last beat")

endmodule

bind cosine_similarity_unit cosu_checker #(
    .MAX_LEN (MAX_LEN)
) u_cosu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_sim   (o_out.similarity),
    .i_out_zero  (o_out.zero_norm),
    .i_out_cnt   (o_out.element_count)
);
